// ===== design/upg_pkg.sv =====
// shared types, codes and constants for the user presence gate
package upg_pkg;

  localparam int unsigned TAG_BYTES   = 8;
  localparam int unsigned TAG_W       = 8 * TAG_BYTES;
  localparam int unsigned TTL_W       = 32;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned IN_TDATA_W  = 208;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [TTL_W-1:0] TTL_RESET       = 32'd30000;
  localparam logic [1:0]       RELEASES_TO_ARM = 2'd2;
  localparam logic [3:0]       TAG_LEN_MATCH   = 4'(TAG_BYTES);

  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_BUTTON  = 3'd1,
    CMD_CONFIRM = 3'd2,
    CMD_CONSUME = 3'd3,
    CMD_CANCEL  = 3'd4,
    CMD_EXPIRY  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_AWAIT     = 2'd1,
    PH_CONFIRMED = 2'd2
  } phase_t;

  // one request as unpacked from the input stream
  typedef struct packed {
    cmd_t               command;
    logic [2:0]         operation_kind;
    logic [63:0]        attempt_tag;
    logic [3:0]         presented_tag_bytes;
    logic [TIME_W-1:0]  now_ms;
    logic [63:0]        btn_gen;
    logic               pressed;
  } req_t;

  // one result before packing onto the output stream
  typedef struct packed {
    logic               accepted;
    phase_t             gate_state;
    logic [2:0]         current_operation;
    logic               armed;
    logic [TIME_W-1:0]  deadline_ms;
  } res_t;

  // gate state held across requests
  typedef struct packed {
    phase_t             phase;
    logic [2:0]         op;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  expiry;
    logic [63:0]        start_gen;
    logic [1:0]         rel_cnt;
    logic               armed;
  } gate_st_t;

  localparam gate_st_t ST_CLEAR = '{
    phase:     PH_IDLE,
    op:        3'd0,
    tag:       '0,
    expiry:    '0,
    start_gen: 64'd0,
    rel_cnt:   2'd0,
    armed:     1'b0
  };

endpackage

// ===== design/upg_in_stage.sv =====
// input register: unpacks and holds one request until the core takes it
module upg_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [upg_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                take,
  output logic                                req_vld,
  output upg_pkg::req_t                       req
);

  logic          vld_r;
  logic          vld_nxt;
  upg_pkg::req_t req_r;
  upg_pkg::req_t req_nxt;

  assign in_tready = !vld_r || take;

  always_comb begin
    req_nxt.command             = upg_pkg::cmd_t'(in_tdata[2:0]);
    req_nxt.operation_kind      = in_tdata[5:3];
    req_nxt.attempt_tag         = in_tdata[69:6];
    req_nxt.presented_tag_bytes = in_tdata[73:70];
    req_nxt.now_ms              = in_tdata[137:74];
    req_nxt.btn_gen             = in_tdata[201:138];
    req_nxt.pressed             = in_tdata[202];
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_tready) begin
      vld_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= req_nxt;
    end
  end

  assign req_vld = vld_r;
  assign req     = req_r;

endmodule

// ===== design/upg_gate_core.sv =====
// gate state and the per-command update logic
module upg_gate_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  upg_pkg::req_t                  req,
  input  logic [upg_pkg::TTL_W-1:0]      ttl,
  output upg_pkg::res_t                  res
);

  upg_pkg::gate_st_t           st_r;
  upg_pkg::gate_st_t           st_nxt;
  logic                        ok;
  logic                        expired;
  logic [upg_pkg::TIME_W:0]    dl_sum;
  logic [upg_pkg::TIME_W-1:0]  dl_sat;
  logic                        tag_match;

  // deadline = now + ttl, saturating at all ones
  assign dl_sum = {1'b0, req.now_ms} + (upg_pkg::TIME_W+1)'(ttl);
  assign dl_sat = dl_sum[upg_pkg::TIME_W] ? '1 : dl_sum[upg_pkg::TIME_W-1:0];

  assign expired   = (st_r.phase != upg_pkg::PH_IDLE) && (req.now_ms >= st_r.expiry);
  assign tag_match = (req.presented_tag_bytes == upg_pkg::TAG_LEN_MATCH) &&
                     (req.attempt_tag[upg_pkg::TAG_W-1:0] == st_r.tag);

  always_comb begin
    st_nxt = st_r;
    ok     = 1'b0;
    unique case (req.command)
      upg_pkg::CMD_BEGIN: begin
        st_nxt           = upg_pkg::ST_CLEAR;
        st_nxt.op        = req.operation_kind;
        st_nxt.tag       = req.attempt_tag[upg_pkg::TAG_W-1:0];
        st_nxt.expiry    = dl_sat;
        st_nxt.start_gen = req.btn_gen;
        st_nxt.phase     = upg_pkg::PH_AWAIT;
        ok               = 1'b1;
      end
      upg_pkg::CMD_BUTTON: begin
        if (st_r.phase == upg_pkg::PH_AWAIT && !st_r.armed) begin
          if (req.pressed) begin
            st_nxt.rel_cnt = 2'd0;
          end else begin
            if (st_r.rel_cnt < upg_pkg::RELEASES_TO_ARM) begin
              st_nxt.rel_cnt = st_r.rel_cnt + 2'd1;
            end
            if (st_nxt.rel_cnt >= upg_pkg::RELEASES_TO_ARM) begin
              st_nxt.armed = 1'b1;
            end
          end
        end
      end
      upg_pkg::CMD_CONFIRM: begin
        if (expired) begin
          st_nxt = upg_pkg::ST_CLEAR;
        end else if (st_r.phase == upg_pkg::PH_AWAIT && st_r.armed &&
                     req.btn_gen > st_r.start_gen) begin
          st_nxt.phase = upg_pkg::PH_CONFIRMED;
          ok           = 1'b1;
        end
      end
      upg_pkg::CMD_CONSUME: begin
        if (expired) begin
          st_nxt = upg_pkg::ST_CLEAR;
        end else if (st_r.phase == upg_pkg::PH_CONFIRMED) begin
          ok     = tag_match;
          st_nxt = upg_pkg::ST_CLEAR;
        end
      end
      upg_pkg::CMD_CANCEL: begin
        st_nxt = upg_pkg::ST_CLEAR;
      end
      upg_pkg::CMD_EXPIRY: begin
        if (expired) begin
          st_nxt = upg_pkg::ST_CLEAR;
          ok     = 1'b1;
        end
      end
      default: begin
        st_nxt = st_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= upg_pkg::ST_CLEAR;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  assign res.accepted          = ok;
  assign res.gate_state        = st_nxt.phase;
  assign res.current_operation = st_nxt.op;
  assign res.armed             = st_nxt.armed;
  assign res.deadline_ms       = st_nxt.expiry;

  a_begin_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.command == upg_pkg::CMD_BEGIN |=> st_r.phase == upg_pkg::PH_AWAIT)
    else $error("begin did not enter awaiting");

  a_idle_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == upg_pkg::PH_IDLE |-> st_r.expiry == '0 && !st_r.armed)
    else $error("idle gate holds a deadline or armed flag");

  a_confirm_needs_armed: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == upg_pkg::PH_CONFIRMED |-> st_r.armed)
    else $error("confirmed without armed input");

  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req.command == upg_pkg::CMD_CONSUME && st_r.phase == upg_pkg::PH_CONFIRMED
    |=> st_r.phase == upg_pkg::PH_IDLE)
    else $error("consume left the gate open");

endmodule

// ===== design/upg_out_stage.sv =====
// result register: packs one result and holds it until the sink takes it
module upg_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  upg_pkg::res_t                       res,
  output logic                                load_ok,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [upg_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic                              vld_r;
  logic                              vld_nxt;
  logic [upg_pkg::OUT_TDATA_W-1:0]   data_r;
  logic [upg_pkg::OUT_TDATA_W-1:0]   data_nxt;

  assign load_ok = !vld_r || out_tready;

  assign data_nxt = {1'b0, res.deadline_ms, res.armed, res.current_operation,
                     res.gate_state, res.accepted};

  always_comb begin
    vld_nxt = vld_r;
    if (load_ok) begin
      vld_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;

endmodule

// ===== design/user_presence_gate.sv =====
// top level of the user presence gate: input register, gate core, result register
//
//  channel  dir  handshake             payload
//  in_      in   in_tvalid/in_tready   in_tdata: one command request
//  out_     out  out_tvalid/out_tready out_tdata: one result per request
//  cfg_     in   cfg_wr_en             cfg_wr_data: attempt lifetime in ms
//
// a request waits in the input register until the result register can take it;
// the gate core forms the result combinationally and updates its state as the
// result register captures it, so throughput is one request per cycle while the
// sink does not stall. the state register feeds back directly, so a request
// always sees the state left by the one before it. reset (rst_n low, synchronous)
// idles the gate and sets the lifetime to 30000 ms. a stalled sink holds the
// result register; the input register takes at most one more request.
module user_presence_gate (
  input  logic                                clk,
  input  logic                                rst_n,
  // command, operation_kind, attempt_tag, presented_tag_bytes, now_ms,
  // btn_gen, pressed, zero fill (lowest bit up)
  input  logic [upg_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // accepted, gate_state, current_operation, armed, deadline_ms, zero fill
  output logic [upg_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_wr_en,
  input  logic [upg_pkg::TTL_W-1:0]           cfg_wr_data
);

  logic [upg_pkg::TTL_W-1:0]   ttl_val_r;
  logic                        req_vld;
  upg_pkg::req_t               req;
  upg_pkg::res_t               res;
  logic                        load_ok;
  logic                        take;

  // lifetime register; user must write only while the gate is quiet, not enforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_val_r <= upg_pkg::TTL_RESET;
    end else if (cfg_wr_en) begin
      ttl_val_r <= cfg_wr_data;
    end
  end

  // a held request moves on whenever the result register can take it
  assign take = req_vld && load_ok;

  upg_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (take),
    .req_vld   (req_vld),
    .req       (req)
  );

  upg_gate_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (take),
    .req   (req),
    .ttl   (ttl_val_r),
    .res   (res)
  );

  upg_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (req_vld),
    .res        (res),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // a lifetime write shows up in the register on the next cycle
  a_cfg_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> ttl_val_r == $past(cfg_wr_data))
    else $error("lifetime write lost");

endmodule

// ===== tb/tb_user_presence_gate.sv =====
// self-checking stream testbench for the user presence gate with a built-in gate predictor
module tb_user_presence_gate;
  timeunit 1ns;
  timeprecision 1ps;

  // spare command codes, outside the defined set, that must leave the gate alone
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam logic [63:0] TIME_MAX    = '1;
  localparam logic [63:0] TAG_KEEP    = {64{1'b1}} >> (64 - upg_pkg::TAG_W);
  localparam int          STALL_LIMIT = 3000;
  localparam int          HOLD_OFF    = 300;
  localparam int          SHOWN_ERRS  = 10;
  localparam int          PHASE_ITEMS = 205;

  // one command request, one field per input of the gate
  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  kind;
    logic [63:0] tag;
    logic [3:0]  tag_len;
    logic [63:0] now_ms;
    logic [63:0] gen;
    logic        pressed;
  } presence_req_t;

  // one result as the gate reports it
  typedef struct packed {
    logic        accepted;
    logic [1:0]  state;
    logic [2:0]  op;
    logic        armed;
    logic [63:0] deadline;
  } presence_res_t;

  // predicted gate state
  typedef struct packed {
    upg_pkg::phase_t ph;
    logic [2:0]      op;
    logic [63:0]     tag;
    logic [63:0]     deadline;
    logic [63:0]     base_gen;
    logic [1:0]      releases;
    logic            armed;
  } gate_t;

  localparam gate_t GATE_IDLE = '{
    ph:       upg_pkg::PH_IDLE,
    op:       3'd0,
    tag:      64'd0,
    deadline: 64'd0,
    base_gen: 64'd0,
    releases: 2'd0,
    armed:    1'b0
  };

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_SEND_GAPS,
    TRAFFIC_SINK_STALLS,
    TRAFFIC_BOTH
  } traffic_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic [upg_pkg::IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                            in_tvalid   = 1'b0;
  logic                            in_tready;
  logic [upg_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready  = 1'b0;
  logic                            cfg_wr_en   = 1'b0;
  logic [upg_pkg::TTL_W-1:0]       cfg_wr_data = '0;

  user_presence_gate i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // requests waiting to be offered, head is the one on the bus
  presence_req_t cmd_backlog[$];
  presence_req_t offered_req;
  // gate results predicted but not yet seen on the output
  presence_res_t pending_outcomes[$];

  gate_t                     gate;
  logic [upg_pkg::TTL_W-1:0] lifetime_model;   // lifetime as the gate holds it
  logic [upg_pkg::TTL_W-1:0] lifetime_now;     // lifetime the stimulus is shaped for
  traffic_t                  traffic      = TRAFFIC_FULL;
  int                        hold_cycles  = 0;
  int                        quiet_cycles = 0;
  int                        error_count  = 0;
  int                        result_count = 0;
  int                        issued       = 0;
  logic                      in_taken     = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- helpers

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // times mostly moderate, some near zero, some near the top of the range
  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return rand64();
      1:       return TIME_MAX - 64'($urandom_range(0, 40000));
      2:       return 64'($urandom_range(0, 1000));
      default: return {24'd0, 8'($urandom_range(0, 255)), $urandom};
    endcase
  endfunction

  // a time after start: mostly before the deadline, some at or past it
  function automatic logic [63:0] later(logic [63:0] start);
    logic [63:0] off;
    logic [64:0] sum;
    case ($urandom_range(0, 7))
      0:       off = 64'(lifetime_now) + 64'($urandom_range(0, 3));
      1:       off = (lifetime_now == 0) ? 64'd0 : 64'(lifetime_now - 1);
      default: off = (lifetime_now == 0) ? 64'd0 : 64'($urandom_range(0, lifetime_now - 1));
    endcase
    sum = {1'b0, start} + {1'b0, off};
    return sum[64] ? TIME_MAX : sum[63:0];
  endfunction

  function automatic presence_req_t rand_req();
    presence_req_t r;
    r.cmd     = 3'($urandom_range(0, 5));
    r.kind    = 3'($urandom_range(0, 7));
    r.tag     = rand64();
    r.tag_len = 4'($urandom_range(0, 8));
    r.now_ms  = pick_time();
    r.gen     = rand64();
    r.pressed = 1'($urandom_range(0, 1));
    return r;
  endfunction

  function automatic logic [upg_pkg::IN_TDATA_W-1:0] pack_req(presence_req_t r);
    return {5'd0, r.pressed, r.gen, r.now_ms, r.tag_len, r.tag, r.kind, r.cmd};
  endfunction

  function automatic bit sender_rests();
    case (traffic)
      TRAFFIC_SEND_GAPS: return $urandom_range(0, 99) < 80;
      TRAFFIC_BOTH:      return $urandom_range(0, 99) < 26;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic bit sink_rests();
    case (traffic)
      TRAFFIC_SINK_STALLS: return $urandom_range(0, 99) < 80;
      TRAFFIC_BOTH:        return $urandom_range(0, 99) < 26;
      default:             return 1'b0;
    endcase
  endfunction

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= SHOWN_ERRS) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------- gate predictor

  // applies one command to the predicted gate and returns the result it reports
  function automatic presence_res_t advance_gate(presence_req_t r);
    presence_res_t res;
    logic [64:0]   sum;
    logic          ok;
    logic          lapsed;
    ok     = 1'b0;
    // a live attempt whose deadline has been reached
    lapsed = (gate.ph != upg_pkg::PH_IDLE) && (r.now_ms >= gate.deadline);
    case (r.cmd)
      upg_pkg::CMD_BEGIN: begin
        gate          = GATE_IDLE;
        gate.op       = r.kind;
        gate.tag      = r.tag & TAG_KEEP;
        // deadline saturates at the top of the time range
        sum           = {1'b0, r.now_ms} + {33'd0, lifetime_model};
        gate.deadline = sum[64] ? TIME_MAX : sum[63:0];
        gate.base_gen = r.gen;
        gate.ph       = upg_pkg::PH_AWAIT;
        ok            = 1'b1;
      end
      upg_pkg::CMD_BUTTON: begin
        // release samples only count while awaiting and not yet armed
        if (gate.ph == upg_pkg::PH_AWAIT && !gate.armed) begin
          if (r.pressed) begin
            gate.releases = 2'd0;
          end else begin
            if (gate.releases < upg_pkg::RELEASES_TO_ARM) begin
              gate.releases = gate.releases + 2'd1;
            end
            if (gate.releases >= upg_pkg::RELEASES_TO_ARM) gate.armed = 1'b1;
          end
        end
      end
      upg_pkg::CMD_CONFIRM: begin
        if (lapsed) begin
          gate = GATE_IDLE;
        end else if (gate.ph == upg_pkg::PH_AWAIT && gate.armed &&
                     r.gen > gate.base_gen) begin
          gate.ph = upg_pkg::PH_CONFIRMED;
          ok      = 1'b1;
        end
      end
      upg_pkg::CMD_CONSUME: begin
        // a confirmed attempt is used up whether or not the tag matches
        if (lapsed) begin
          gate = GATE_IDLE;
        end else if (gate.ph == upg_pkg::PH_CONFIRMED) begin
          ok   = (r.tag_len == upg_pkg::TAG_LEN_MATCH) &&
                 ((r.tag & TAG_KEEP) == gate.tag);
          gate = GATE_IDLE;
        end
      end
      upg_pkg::CMD_CANCEL: begin
        gate = GATE_IDLE;
      end
      upg_pkg::CMD_EXPIRY: begin
        ok = lapsed;
        if (lapsed) gate = GATE_IDLE;
      end
      default: begin
      end
    endcase
    res.accepted = ok;
    res.state    = gate.ph;
    res.op       = gate.op;
    res.armed    = gate.armed;
    res.deadline = gate.deadline;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic queue_req(input presence_req_t r);
    cmd_backlog.push_back(r);
    issued++;
  endtask

  task automatic queue_fields(input logic [2:0] cmd, input logic [2:0] kind,
                              input logic [63:0] tag, input logic [3:0] tag_len,
                              input logic [63:0] now_ms, input logic [63:0] gen,
                              input logic pressed);
    presence_req_t r;
    r = '{cmd: cmd, kind: kind, tag: tag, tag_len: tag_len, now_ms: now_ms, gen: gen,
          pressed: pressed};
    queue_req(r);
  endtask

  // walks the gate through the named corner cases with the reset lifetime
  task automatic queue_directed();
    logic [63:0] t;
    t = rand64();
    // commands against an idle gate
    queue_fields(upg_pkg::CMD_CONSUME, 3'd2, t, upg_pkg::TAG_LEN_MATCH, 64'd5, 64'd0, 1'b1);
    queue_fields(upg_pkg::CMD_EXPIRY, 3'd0, t, 4'd0, TIME_MAX, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    // attempt at time zero, press in between releases restarts the count
    queue_fields(upg_pkg::CMD_BEGIN, 3'd0, 64'd0, 4'd0, 64'd0, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b1);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b1);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    // not armed yet
    queue_fields(upg_pkg::CMD_CONFIRM, 3'd0, t, 4'd0, 64'd10, 64'd1, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    // already armed, sample ignored
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b1);
    // generation not newer, then consume before confirm
    queue_fields(upg_pkg::CMD_CONFIRM, 3'd0, t, 4'd0, 64'd20, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_CONSUME, 3'd0, 64'd0, upg_pkg::TAG_LEN_MATCH, 64'd20, 64'd0,
                 1'b0);
    // confirm and consume on the last millisecond
    queue_fields(upg_pkg::CMD_CONFIRM, 3'd0, t, 4'd0, 64'd29999, 64'd1, 1'b0);
    queue_fields(upg_pkg::CMD_CONSUME, 3'd0, 64'd0, upg_pkg::TAG_LEN_MATCH, 64'd29999, 64'd0,
                 1'b0);
    // saturating deadline, spare operation kind, short tag length
    queue_fields(upg_pkg::CMD_BEGIN, 3'd7, TIME_MAX, 4'd0, TIME_MAX - 64'd10,
                 TIME_MAX - 64'd1, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_BUTTON, 3'd0, t, 4'd0, 64'd0, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_CONFIRM, 3'd0, t, 4'd0, TIME_MAX - 64'd1, TIME_MAX, 1'b0);
    queue_fields(upg_pkg::CMD_CONSUME, 3'd0, TIME_MAX, 4'd7, TIME_MAX - 64'd1, 64'd0, 1'b0);
    // expiry check one before and at the deadline
    queue_fields(upg_pkg::CMD_BEGIN, 3'd6, t, 4'd0, 64'd100, 64'd5, 1'b0);
    queue_fields(upg_pkg::CMD_EXPIRY, 3'd0, t, 4'd0, 64'd30099, 64'd0, 1'b0);
    queue_fields(upg_pkg::CMD_EXPIRY, 3'd0, t, 4'd0, 64'd30100, 64'd0, 1'b0);
    // cancel, spare commands on a live attempt
    queue_fields(upg_pkg::CMD_BEGIN, 3'd5, t, 4'd0, 64'd500, 64'd9, 1'b0);
    queue_fields(CMD_SPARE_A, 3'd1, t, 4'd8, 64'd600, 64'd10, 1'b1);
    queue_fields(CMD_SPARE_B, 3'd2, t, 4'd8, 64'd600, 64'd10, 1'b0);
    queue_fields(upg_pkg::CMD_CANCEL, 3'd0, t, 4'd0, 64'd600, 64'd0, 1'b0);
  endtask

  // a begin, releases with random presses, confirm and consume, with random faults
  task automatic queue_attempt();
    presence_req_t r;
    logic [63:0]   start;
    logic [63:0]   gen0;
    logic [63:0]   tag0;
    int            rel_run;
    start     = pick_time();
    gen0      = rand64();
    r         = rand_req();
    r.cmd     = upg_pkg::CMD_BEGIN;
    r.now_ms  = start;
    r.gen     = gen0;
    tag0      = r.tag;
    queue_req(r);
    rel_run = 0;
    while (rel_run < 2) begin
      r         = rand_req();
      r.cmd     = upg_pkg::CMD_BUTTON;
      r.pressed = ($urandom_range(0, 3) == 0);
      rel_run   = r.pressed ? 0 : rel_run + 1;
      queue_req(r);
    end
    // occasional interference before the confirm
    if ($urandom_range(0, 7) == 0) begin
      r = rand_req();
      case ($urandom_range(0, 3))
        0: r.cmd = upg_pkg::CMD_CANCEL;
        1: r.cmd = upg_pkg::CMD_BEGIN;
        2: r.cmd = upg_pkg::CMD_BUTTON;
        default: begin
          r.cmd    = upg_pkg::CMD_EXPIRY;
          r.now_ms = later(start);
        end
      endcase
      queue_req(r);
    end
    r        = rand_req();
    r.cmd    = upg_pkg::CMD_CONFIRM;
    r.now_ms = later(start);
    case ($urandom_range(0, 7))
      0:       r.gen = gen0;
      1:       r.gen = gen0 - 64'($urandom_range(1, 3));
      default: r.gen = gen0 + 64'($urandom_range(1, 4));
    endcase
    queue_req(r);
    r         = rand_req();
    r.cmd     = upg_pkg::CMD_CONSUME;
    r.now_ms  = later(start);
    r.tag     = tag0;
    r.tag_len = upg_pkg::TAG_LEN_MATCH;
    case ($urandom_range(0, 5))
      0:       r.tag = tag0 ^ (64'd1 << $urandom_range(0, 63));
      1:       r.tag_len = 4'($urandom_range(0, 7));
      default: begin
      end
    endcase
    queue_req(r);
  endtask

  task automatic queue_noise();
    presence_req_t r;
    r = rand_req();
    if ($urandom_range(0, 39) == 0) r.cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
    queue_req(r);
  endtask

  // write the lifetime register, only while nothing is in flight
  task automatic write_lifetime(input logic [upg_pkg::TTL_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lifetime_now = v;
  endtask

  // wait until every request was taken and every result came back
  task automatic drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || in_tvalid || pending_outcomes.size() != 0);
  endtask

  // ---------------------------------------------------------------- driver

  // offers the head of the backlog, holds it until taken, random gaps between requests
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_taken) void'(cmd_backlog.pop_front());
      if (in_tvalid && !in_taken) begin
        // request still waiting for ready, keep it on the bus
      end else if (cmd_backlog.size() != 0 && !sender_rests()) begin
        in_tdata    <= pack_req(cmd_backlog[0]);
        offered_req <= cmd_backlog[0];
        in_tvalid   <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // sink side: random stalls, plus one long hold-off counted down here
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !sink_rests();
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_result(input logic [upg_pkg::OUT_TDATA_W-1:0] d);
    presence_res_t got;
    presence_res_t want;
    got.accepted = d[0];
    got.state    = d[2:1];
    got.op       = d[5:3];
    got.armed    = d[6];
    got.deadline = d[70:7];
    result_count++;
    if (pending_outcomes.size() == 0) begin
      flag_error($sformatf("result %0d arrived with none expected: %h", result_count, d));
      return;
    end
    want = pending_outcomes.pop_front();
    if (got.accepted !== want.accepted || got.state !== want.state || got.op !== want.op ||
        got.armed !== want.armed || got.deadline !== want.deadline)
      flag_error($sformatf({"result %0d: expected acc %0b st %0d op %0d arm %0b dl %h, ",
                            "got acc %0b st %0d op %0d arm %0b dl %h"}, result_count,
                           want.accepted, want.state, want.op, want.armed, want.deadline,
                           got.accepted, got.state, got.op, got.armed, got.deadline));
  endtask

  // samples both handshakes and the config port at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (!rst_n) begin
      gate           = GATE_IDLE;
      lifetime_model = upg_pkg::TTL_RESET;
      quiet_cycles   = 0;
    end else begin
      if (cfg_wr_en) lifetime_model = cfg_wr_data;
      if (in_tvalid && in_tready) pending_outcomes.push_back(advance_gate(offered_req));
      if (out_tvalid && out_tready) check_result(out_tdata);
      // watchdog: too long without any request or result moving
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------- test sequence

  initial begin
    logic [upg_pkg::TTL_W-1:0] lifetime_plan [6];
    traffic_t                  traffic_plan  [6];
    int                        target;
    lifetime_plan[0] = 32'hFFFF_FFFF;
    lifetime_plan[1] = 32'd1;
    lifetime_plan[2] = 32'd0;
    lifetime_plan[3] = 32'($urandom_range(2, 100000));
    lifetime_plan[4] = upg_pkg::TTL_RESET;
    lifetime_plan[5] = $urandom;
    traffic_plan[0]  = TRAFFIC_FULL;
    traffic_plan[1]  = TRAFFIC_SEND_GAPS;
    traffic_plan[2]  = TRAFFIC_SINK_STALLS;
    traffic_plan[3]  = TRAFFIC_BOTH;
    traffic_plan[4]  = TRAFFIC_SINK_STALLS;
    traffic_plan[5]  = TRAFFIC_SEND_GAPS;

    // synchronous reset held, then released
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corner cases under the reset lifetime, full rate
    lifetime_now = upg_pkg::TTL_RESET;
    traffic      = TRAFFIC_FULL;
    queue_directed();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_lifetime(lifetime_plan[ph]);
      traffic = traffic_plan[ph];
      target  = issued + PHASE_ITEMS;
      while (issued < target) begin
        if ($urandom_range(0, 9) < 7) queue_attempt();
        else queue_noise();
      end
      // long sink hold-off while the sender keeps offering at full rate
      if (ph == 0) begin
        @(posedge clk);
        hold_cycles = HOLD_OFF;
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (pending_outcomes.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_outcomes.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/upg_pkg.sv
design/upg_in_stage.sv
design/upg_gate_core.sv
design/upg_out_stage.sv
design/user_presence_gate.sv
tb/tb_user_presence_gate.sv
